// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the RTL. They vanish in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every rising edge outside reset.
`define SAT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("segment translator assertion failed");

// Checked on every rising edge, reset included.
`define SAT_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("segment translator assertion failed");

`else

`define SAT_ASSERT(label, clk, rst_n, prop)
`define SAT_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ----- hw/rtl/sat_pkg.sv -----
package sat_pkg;

  localparam int TABLE_SLOTS_DEF = 16;
  localparam int QUEUE_DEPTH     = 2;
  localparam int DATA_W          = 32;
  localparam int PADDR_W         = 31;

  // Request type codes on the input port.
  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_XLATE = 2'd2;

  // Fault codes on the result port.
  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_NOSEG = 2'd1;
  localparam logic [1:0] FAULT_RANGE = 2'd2;

  typedef logic [1:0] kind_t;

  // Work kinds after classification in the front end.
  localparam kind_t KIND_CLEAR = 2'd0;
  localparam kind_t KIND_WRITE = 2'd1;
  localparam kind_t KIND_XLATE = 2'd2;
  localparam kind_t KIND_NOP   = 2'd3;

  typedef struct packed {
    kind_t               kind;
    logic [3:0]          slot;
    logic [DATA_W-1:0]   seg_id;
    logic [PADDR_W-1:0]  base;
    logic [DATA_W-1:0]   limit;
    logic [DATA_W-1:0]   addr;
    logic [DATA_W-1:0]   size;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0]   seg_id;
    logic [PADDR_W-1:0]  base;
    logic [DATA_W-1:0]   limit;
  } entry_t;

  // Queue head as seen by the back end.
  typedef struct packed {
    logic valid;
    req_t req;
  } head_t;

endpackage

// ----- hw/rtl/sat_front.sv -----
module sat_front import sat_pkg::*; #(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_req_type,
  input  logic [3:0]         in_entry_slot,
  input  logic [DATA_W-1:0]  in_entry_seg_id,
  input  logic [PADDR_W-1:0] in_entry_base,
  input  logic [DATA_W-1:0]  in_entry_limit,
  input  logic [DATA_W-1:0]  in_logical_addr,
  input  logic [DATA_W-1:0]  in_access_size,
  output head_t              head,
  input  logic               pop
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [8:0]       SLOTS_LIM = 9'(TABLE_SLOTS);

  req_t             q_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  req_t             cls_req;
  logic             push;
  logic             do_pop;

  // Classification: writes to a slot that does not exist become no-ops.
  always_comb begin
    cls_req.slot   = in_entry_slot;
    cls_req.seg_id = in_entry_seg_id;
    cls_req.base   = in_entry_base;
    cls_req.limit  = in_entry_limit;
    cls_req.addr   = in_logical_addr;
    cls_req.size   = in_access_size;
    case (in_req_type)
      REQ_CLEAR: cls_req.kind = KIND_CLEAR;
      REQ_WRITE: cls_req.kind = ({5'd0, in_entry_slot} < SLOTS_LIM) ? KIND_WRITE : KIND_NOP;
      REQ_XLATE: cls_req.kind = KIND_XLATE;
      default:   cls_req.kind = KIND_NOP;
    endcase
  end

  assign busy   = (count_r == FULL_CNT);
  assign push   = start && !busy;
  assign do_pop = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= cls_req;
    end
  end

  assign head.valid = (count_r != '0);
  assign head.req   = q_mem[rd_ptr_r];

endmodule

// ----- hw/rtl/sat_div.sv -----
module sat_div import sat_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic              done,
  output logic [DATA_W-1:0] quotient,
  output logic [DATA_W-1:0] remainder
);

  localparam int STEP_W = $clog2(DATA_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DATA_W - 1);

  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DATA_W-1:0] quo_r, quo_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   diff;
  logic              ge;

  // Restoring division, one quotient bit per cycle. The dividend shifts out
  // of the top of quo_r while quotient bits shift in at the bottom. A zero
  // divisor yields an all-ones quotient and the dividend as remainder.
  assign rem_sh = {rem_r, quo_r[DATA_W-1]};
  assign ge     = (rem_sh >= {1'b0, divisor});
  assign diff   = rem_sh - {1'b0, divisor};

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (go) begin
      run_nxt  = 1'b1;
      step_nxt = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
    end else if (run_r) begin
      quo_nxt  = {quo_r[DATA_W-2:0], ge};
      rem_nxt  = ge ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
      step_nxt = step_r + 1'b1;
      if (step_r == LAST_STEP) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ----- hw/rtl/sat_back.sv -----
module sat_back import sat_pkg::*; #(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [DATA_W-1:0]  seg_max_size,
  input  head_t              head,
  output logic               pop,
  output logic               out_valid,
  output logic [PADDR_W-1:0] out_phys_addr,
  output logic [1:0]         out_fault_kind
);

  localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
  localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(TABLE_SLOTS);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DIV   = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_CHECK = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic [TABLE_SLOTS-1:0] valid_r, valid_nxt;
  entry_t                 tbl_mem [TABLE_SLOTS];
  entry_t                 rd_q;
  logic [CNT_W-1:0]       scan_idx_r, scan_idx_nxt;
  logic                   cmp_vld_r, cmp_vld_nxt;
  logic [SLOT_W-1:0]      cmp_idx_r, cmp_idx_nxt;
  logic [DATA_W-1:0]      size_r, size_nxt;
  logic [PADDR_W-1:0]     hit_base_r, hit_base_nxt;
  logic [DATA_W-1:0]      hit_limit_r, hit_limit_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [PADDR_W-1:0]     out_phys_r, out_phys_nxt;
  logic [1:0]             out_fault_r, out_fault_nxt;
  logic                   wr_en;
  logic [SLOT_W-1:0]      wr_idx;
  logic                   rd_en;
  logic                   issue;
  logic                   hit;
  logic                   div_go;
  logic                   div_done;
  logic [DATA_W-1:0]      seg_no;
  logic [DATA_W-1:0]      offset;
  logic [DATA_W:0]        span;
  logic [DATA_W:0]        phys_sum;
  logic                   over_limit;
  logic                   over_addr;

  sat_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (div_go),
    .dividend  (head.req.addr),
    .divisor   (seg_max_size),
    .done      (div_done),
    .quotient  (seg_no),
    .remainder (offset)
  );

  assign wr_idx = SLOT_W'(head.req.slot);
  assign issue  = (scan_idx_r < SCAN_END);
  assign hit    = cmp_vld_r && valid_r[cmp_idx_r] && (rd_q.seg_id == seg_no);

  assign span       = {1'b0, offset} + {1'b0, size_r};
  assign over_limit = (span > {1'b0, hit_limit_r});
  assign phys_sum   = {2'b00, hit_base_r} + {1'b0, offset};
  assign over_addr  = (phys_sum[DATA_W:PADDR_W] != '0);

  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    scan_idx_nxt  = scan_idx_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    size_nxt      = size_r;
    hit_base_nxt  = hit_base_r;
    hit_limit_nxt = hit_limit_r;
    out_valid_nxt = 1'b0;
    out_phys_nxt  = '0;
    out_fault_nxt = FAULT_NONE;
    pop           = 1'b0;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    div_go        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          case (head.req.kind)
            KIND_CLEAR: begin
              valid_nxt     = '0;
              out_valid_nxt = 1'b1;
            end
            KIND_WRITE: begin
              wr_en             = 1'b1;
              valid_nxt[wr_idx] = 1'b1;
              out_valid_nxt     = 1'b1;
            end
            KIND_XLATE: begin
              div_go    = 1'b1;
              size_nxt  = head.req.size;
              state_nxt = ST_DIV;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          scan_idx_nxt = '0;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Read one slot per cycle; compare it the cycle after.
        if (issue) begin
          rd_en        = 1'b1;
          scan_idx_nxt = scan_idx_r + 1'b1;
          cmp_idx_nxt  = scan_idx_r[SLOT_W-1:0];
          cmp_vld_nxt  = 1'b1;
        end
        if (hit) begin
          hit_base_nxt  = rd_q.base;
          hit_limit_nxt = rd_q.limit;
          cmp_vld_nxt   = 1'b0;
          state_nxt     = ST_CHECK;
        end else if (!issue && !cmp_vld_r) begin
          out_valid_nxt = 1'b1;
          out_fault_nxt = FAULT_NOSEG;
          state_nxt     = ST_IDLE;
        end
      end
      ST_CHECK: begin
        out_valid_nxt = 1'b1;
        if (over_limit || over_addr) begin
          out_fault_nxt = FAULT_RANGE;
        end else begin
          out_phys_nxt = phys_sum[PADDR_W-1:0];
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      scan_idx_r  <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      scan_idx_r  <= scan_idx_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r   <= cmp_idx_nxt;
    size_r      <= size_nxt;
    hit_base_r  <= hit_base_nxt;
    hit_limit_r <= hit_limit_nxt;
    out_phys_r  <= out_phys_nxt;
    out_fault_r <= out_fault_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl_mem[wr_idx] <= '{seg_id: head.req.seg_id, base: head.req.base,
                           limit: head.req.limit};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= tbl_mem[scan_idx_r[SLOT_W-1:0]];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_phys_addr  = out_phys_r;
  assign out_fault_kind = out_fault_r;

endmodule

// ----- hw/rtl/segment_address_translator.sv -----
// Segment address translator. A request is taken when start is high and busy
// is low; a two-entry request queue sits in front of the execution engine, so
// one request can be handed in while another is being worked on. Every request
// produces exactly one result, shown for a single cycle with out_valid high;
// the receiver cannot stall it and must take it in that cycle. A clear, a slot
// write or an unknown request type is answered through the result register,
// with no divide and no table scan. A translation first runs the bit-serial
// 32-bit divider that splits the logical address, then scans the segment
// table memory one slot per cycle through its single read port, from the
// lowest slot up, and stops at the first slot whose segment id matches; the
// limit and overflow checks on that slot follow. The segment table needs no
// clearing pass after reset, since only the valid bits are reset.
// cfg_wdata loads the maximum segment size; it may be changed only while no
// request is in flight.

`include "assert_macros.svh"

module segment_address_translator import sat_pkg::*; #(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_req_type,
  input  logic [3:0]         in_entry_slot,
  input  logic [DATA_W-1:0]  in_entry_seg_id,
  input  logic [PADDR_W-1:0] in_entry_base,
  input  logic [DATA_W-1:0]  in_entry_limit,
  input  logic [DATA_W-1:0]  in_logical_addr,
  input  logic [DATA_W-1:0]  in_access_size,
  input  logic               cfg_we,
  input  logic [DATA_W-1:0]  cfg_wdata,
  output logic               out_valid,
  output logic [PADDR_W-1:0] out_phys_addr,
  output logic [1:0]         out_fault_kind
);

  // The segment size register resets to one, which makes every address its
  // own segment with offset zero.
  logic [DATA_W-1:0] seg_max_size_r, seg_max_size_nxt;
  head_t             head;
  logic              pop;

  assign seg_max_size_nxt = cfg_we ? cfg_wdata : seg_max_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_max_size_r <= DATA_W'(1);
    end else begin
      seg_max_size_r <= seg_max_size_nxt;
    end
  end

  // Front end: takes requests, sorts out their kind and queues them.
  sat_front #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_entry_slot   (in_entry_slot),
    .in_entry_seg_id (in_entry_seg_id),
    .in_entry_base   (in_entry_base),
    .in_entry_limit  (in_entry_limit),
    .in_logical_addr (in_logical_addr),
    .in_access_size  (in_access_size),
    .head            (head),
    .pop             (pop)
  );

  // Back end: owns the segment table, the divider and the result register.
  sat_back #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .seg_max_size   (seg_max_size_r),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_phys_addr  (out_phys_addr),
    .out_fault_kind (out_fault_kind)
  );

  // The queue is empty right after reset, so requests are welcome at once.
  `SAT_ASSERT_ALWAYS(a_reset_not_busy, clk, !rst_n |=> !busy)

  // The queue can only fill up through a request taken in the cycle before.
  `SAT_ASSERT(a_busy_after_start, clk, rst_n, $rose(busy) |-> $past(start))

  // A faulting translation never leaks an address.
  `SAT_ASSERT(a_fault_zero_addr, clk, rst_n, out_valid && (out_fault_kind != FAULT_NONE) |-> (out_phys_addr == '0))

endmodule

// ----- sim/tb.sv -----
import sat_pkg::*;

// One request as the input port carries it.
typedef struct {
  logic [1:0]         req_type;
  logic [3:0]         slot;
  logic [DATA_W-1:0]  seg_id;
  logic [PADDR_W-1:0] base;
  logic [DATA_W-1:0]  limit;
  logic [DATA_W-1:0]  addr;
  logic [DATA_W-1:0]  size;
} mmu_req_t;

// One translation outcome as the result port carries it.
typedef struct {
  logic [PADDR_W-1:0] phys;
  logic [1:0]         fault;
} xlate_res_t;

// Shadow segment table plus the queue of request outcomes still owed by the block.
class xlate_scoreboard;
  logic [DATA_W-1:0]  seg_size;
  logic               slot_valid  [TABLE_SLOTS_DEF];
  logic [DATA_W-1:0]  slot_seg_id [TABLE_SLOTS_DEF];
  logic [PADDR_W-1:0] slot_base   [TABLE_SLOTS_DEF];
  logic [DATA_W-1:0]  slot_limit  [TABLE_SLOTS_DEF];
  xlate_res_t         outcome_q [$];
  int                 errors;

  function new();
    seg_size = 1;
    errors = 0;
    foreach (slot_valid[k]) begin
      slot_valid[k]  = 1'b0;
      slot_seg_id[k] = '0;
      slot_base[k]   = '0;
      slot_limit[k]  = '0;
    end
  endfunction

  function int pending();
    return outcome_q.size();
  endfunction

  // Applies one accepted request to the shadow table and queues its outcome.
  function void note_request(mmu_req_t r);
    logic [DATA_W-1:0] segno;
    logic [DATA_W-1:0] offs;
    logic [DATA_W:0]   span;
    logic [DATA_W:0]   sum;
    int                hit;
    xlate_res_t        res;
    res.phys  = '0;
    res.fault = FAULT_NONE;
    case (r.req_type)
      REQ_CLEAR: begin
        foreach (slot_valid[k]) slot_valid[k] = 1'b0;
      end
      REQ_WRITE: begin
        if (r.slot < TABLE_SLOTS_DEF) begin
          slot_valid[r.slot]  = 1'b1;
          slot_seg_id[r.slot] = r.seg_id;
          slot_base[r.slot]   = r.base;
          slot_limit[r.slot]  = r.limit;
        end
      end
      REQ_XLATE: begin
        if (seg_size == '0) begin
          segno = '1;
          offs  = r.addr;
        end else begin
          segno = r.addr / seg_size;
          offs  = r.addr % seg_size;
        end
        hit = -1;
        for (int k = 0; k < TABLE_SLOTS_DEF; k++) begin
          if (hit < 0 && slot_valid[k] && slot_seg_id[k] == segno) hit = k;
        end
        if (hit < 0) begin
          res.fault = FAULT_NOSEG;
        end else begin
          span = {1'b0, offs} + {1'b0, r.size};
          sum  = {2'b00, slot_base[hit]} + {1'b0, offs};
          if (span > {1'b0, slot_limit[hit]}) res.fault = FAULT_RANGE;
          else if (sum[DATA_W:PADDR_W] != '0) res.fault = FAULT_RANGE;
          else res.phys = sum[PADDR_W-1:0];
        end
      end
      default: ;
    endcase
    outcome_q.push_back(res);
  endfunction

  function void check_result(logic [PADDR_W-1:0] phys, logic [1:0] fault);
    xlate_res_t want;
    if (outcome_q.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual phys_addr %h fault_kind %0d",
               $time, phys, fault);
      errors++;
      return;
    end
    want = outcome_q.pop_front();
    if (want.phys !== phys) begin
      $display("%0t: phys_addr mismatch: expected %h, actual %h", $time, want.phys, phys);
      errors++;
    end
    if (want.fault !== fault) begin
      $display("%0t: fault_kind mismatch: expected %0d, actual %0d", $time, want.fault, fault);
      errors++;
    end
  endfunction
endclass

module tb;

  // Request type code that the block must treat as a no-op.
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  // Far above the slowest legal run: every request a no-match translation
  // behind the longest sender gap, times about 1830 requests.
  localparam int unsigned LIMIT_CYCLES = 1000000;
  localparam int          PHASE_ITEMS  = 200;
  localparam int          NUM_PHASES   = 9;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         in_req_type;
  logic [3:0]         in_entry_slot;
  logic [DATA_W-1:0]  in_entry_seg_id;
  logic [PADDR_W-1:0] in_entry_base;
  logic [DATA_W-1:0]  in_entry_limit;
  logic [DATA_W-1:0]  in_logical_addr;
  logic [DATA_W-1:0]  in_access_size;
  logic               cfg_we;
  logic [DATA_W-1:0]  cfg_wdata;
  logic               out_valid;
  logic [PADDR_W-1:0] out_phys_addr;
  logic [1:0]         out_fault_kind;

  xlate_scoreboard sb = new();
  int unsigned     cycle_count = 0;

  segment_address_translator dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_entry_slot   (in_entry_slot),
    .in_entry_seg_id (in_entry_seg_id),
    .in_entry_base   (in_entry_base),
    .in_entry_limit  (in_entry_limit),
    .in_logical_addr (in_logical_addr),
    .in_access_size  (in_access_size),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_phys_addr   (out_phys_addr),
    .out_fault_kind  (out_fault_kind)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("segment_address_translator regression: fail");
      $finish;
    end
  end

  // Results cannot be held off, so every strobe is checked on the edge that
  // ends its cycle. Sampling right at the edge sees the pre-edge values.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_phys_addr, out_fault_kind);
  end

  // A request with every field random, so that fields the request type
  // ignores still toggle through all their bits.
  function automatic mmu_req_t noise_req();
    mmu_req_t r;
    r.req_type = 2'($urandom_range(0, 3));
    r.slot     = 4'($urandom_range(0, 15));
    r.seg_id   = $urandom;
    r.base     = 31'($urandom);
    r.limit    = $urandom;
    r.addr     = $urandom;
    r.size     = $urandom;
    return r;
  endfunction

  // Random traffic aimed at the interesting paths. Writes mostly pick segment
  // ids that can actually be reached with the current segment size, and most
  // translations are built from a valid slot so they hit, with offsets and
  // sizes placed around the limit and bases near the top of the physical
  // space to exercise the range and overflow faults.
  function automatic mmu_req_t random_req();
    mmu_req_t          r;
    int unsigned       pick;
    int unsigned       k;
    bit                found;
    logic [DATA_W-1:0] id;
    logic [63:0]       id64;
    logic [63:0]       seg64;
    logic [63:0]       qmax;
    logic [63:0]       off_hi;
    logic [63:0]       off;
    logic [63:0]       lim;
    logic [63:0]       sz;
    logic [63:0]       full;
    r     = noise_req();
    pick  = $urandom_range(0, 99);
    seg64 = {32'd0, sb.seg_size};
    // Highest segment number a 32-bit logical address can reach.
    qmax  = (seg64 == 0) ? 64'hFFFF_FFFF : 64'hFFFF_FFFF / seg64;
    if (pick < 3) begin
      r.req_type = REQ_CLEAR;
    end else if (pick < 5) begin
      r.req_type = REQ_UNKNOWN;
    end else if (pick < 30) begin
      r.req_type = REQ_WRITE;
      case ($urandom_range(0, 3))
        0: r.seg_id = (seg64 == 0) ? '1 : qmax[31:0];
        1: r.seg_id = $urandom;
        default: r.seg_id = $urandom_range(0, (qmax < 20) ? qmax[31:0] : 32'd20);
      endcase
      case ($urandom_range(0, 3))
        0: r.base = 31'(32'h7FFF_FFFF - $urandom_range(0, 4096));
        1: r.base = 31'($urandom_range(0, 4096));
        default: r.base = 31'($urandom);
      endcase
      case ($urandom_range(0, 9))
        0, 1: r.limit = '1;
        2: r.limit = '0;
        3, 4, 5: r.limit = $urandom_range(0, 4096);
        default: r.limit = $urandom;
      endcase
    end else begin
      r.req_type = REQ_XLATE;
      found = 1'b0;
      k = 0;
      if ($urandom_range(0, 3) != 0) begin
        for (int t = 0; t < 16 && !found; t++) begin
          k = $urandom_range(0, TABLE_SLOTS_DEF - 1);
          found = sb.slot_valid[k];
        end
      end
      if (found) begin
        id    = sb.slot_seg_id[k];
        id64  = {32'd0, id};
        found = (seg64 == 0) ? (id == '1) : (id64 <= qmax);
      end
      if (found) begin
        if (seg64 == 0) begin
          off_hi = 64'hFFFF_FFFF;
        end else begin
          off_hi = seg64 - 1;
          if (off_hi > 64'hFFFF_FFFF - id64 * seg64) off_hi = 64'hFFFF_FFFF - id64 * seg64;
        end
        lim = {32'd0, sb.slot_limit[k]};
        case ($urandom_range(0, 3))
          0: off = 64'd0;
          1: off = off_hi;
          2: off = (lim < off_hi) ? lim : off_hi;
          default: off = {$urandom, $urandom} % (off_hi + 1);
        endcase
        full   = (seg64 == 0) ? off : id64 * seg64 + off;
        r.addr = full[31:0];
        case ($urandom_range(0, 9))
          0, 1, 2, 3: sz = (lim >= off) ? lim - off : 64'd0;
          4, 5: sz = lim - off + 64'd1;
          6: sz = 64'd0;
          7: sz = 64'hFFFF_FFFF;
          default: sz = {32'd0, $urandom_range(0, 64)};
        endcase
        r.size = sz[31:0];
      end else if ($urandom_range(0, 1) == 0) begin
        r.size = $urandom_range(0, 64);
      end
    end
    return r;
  endfunction

  // Presents one request, holds it until the block takes it, then leaves
  // start high for back-to-back traffic or drops it for the given gap.
  task automatic send_request(input mmu_req_t r, input int unsigned gap);
    in_req_type     = r.req_type;
    in_entry_slot   = r.slot;
    in_entry_seg_id = r.seg_id;
    in_entry_base   = r.base;
    in_entry_limit  = r.limit;
    in_logical_addr = r.addr;
    in_access_size  = r.size;
    start           = 1'b1;
    do @(posedge clk); while (busy);
    sb.note_request(r);
    @(negedge clk);
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_xlate(input logic [DATA_W-1:0] addr, input logic [DATA_W-1:0] size);
    mmu_req_t r;
    r          = noise_req();
    r.req_type = REQ_XLATE;
    r.addr     = addr;
    r.size     = size;
    send_request(r, 0);
  endtask

  // Stops sending and waits until every outstanding result has come back.
  // Every request yields a result, so an empty queue means the block is idle.
  task automatic wait_idle();
    start = 1'b0;
    while (sb.pending() != 0 || busy) @(posedge clk);
    @(negedge clk);
  endtask

  // The segment size register may only change with nothing in flight.
  task automatic write_seg_size(input logic [DATA_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    sb.seg_size = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    mmu_req_t    r;
    int unsigned gap;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_req_type     = '0;
    in_entry_slot   = '0;
    in_entry_seg_id = '0;
    in_entry_base   = '0;
    in_entry_limit  = '0;
    in_logical_addr = '0;
    in_access_size  = '0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part. Fill every slot first so the table memory holds known
    // data everywhere; slots 1 and 2 share an id to check that the lowest
    // matching slot wins, and slots 3 and 4 sit at the top of both spaces.
    for (int k = 0; k < TABLE_SLOTS_DEF; k++) begin
      r          = noise_req();
      r.req_type = REQ_WRITE;
      r.slot     = 4'(k);
      case (k)
        0: begin r.seg_id = '0; r.base = '0; r.limit = '0; end
        1: begin r.seg_id = 32'd5; r.base = 31'h100; r.limit = 32'd16; end
        2: begin r.seg_id = 32'd5; r.base = 31'h999; r.limit = '1; end
        3: begin r.seg_id = 32'h0FFF_FFFF; r.base = '1; r.limit = '1; end
        4: begin r.seg_id = 32'd7; r.base = 31'h7FFF_FFF0; r.limit = '1; end
        5: r.seg_id = '1;
        default: r.seg_id = 32'h100 + k;
      endcase
      send_request(r, 0);
    end
    // Reset segment size of one: the address is the segment number itself.
    send_xlate(32'd0, 32'd0);

    wait_idle();
    write_seg_size(32'd16);
    send_xlate(32'd0, 32'd1);             // one byte past a zero limit
    send_xlate(32'd95, 32'd1);            // end lands exactly on the limit
    send_xlate(32'd95, 32'd2);            // one byte beyond the limit
    send_xlate('1, 32'd0);                // base plus offset crosses 2^31
    send_xlate(32'd81, '1);               // offset plus size must not wrap
    send_xlate(32'd127, 32'd0);           // highest physical address that fits
    send_xlate(32'd800, 32'd4);           // no slot holds segment 50
    r          = noise_req();
    r.req_type = REQ_UNKNOWN;
    send_request(r, 0);
    r          = noise_req();
    r.req_type = REQ_CLEAR;
    send_request(r, 0);
    send_xlate(32'd95, 32'd1);            // the clear left nothing valid

    // Random phases, each under its own segment size. The drain before each
    // register write is also where the sender waits for every result.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: write_seg_size(32'd1);
        1: write_seg_size(32'd0);
        2: write_seg_size('1);
        3: write_seg_size(32'd4096);
        4: write_seg_size(32'd3);
        5: write_seg_size($urandom);
        6: write_seg_size(32'd7);
        7: write_seg_size(32'h8000_0000);
        default: write_seg_size($urandom_range(2, 64));
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Some phases run flat out, some take a random gap after every request, some mix.
        case (ph % 3)
          0: gap = 0;
          1: gap = $urandom_range(0, 13);
          default: gap = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 13);
        endcase
        send_request(random_req(), gap);
      end
    end

    wait_idle();
    // Give a stray late result time to show up before the verdict.
    repeat (80) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("segment_address_translator regression: pass");
    end else begin
      $display("segment_address_translator regression: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/sat_pkg.sv
hw/rtl/sat_front.sv
hw/rtl/sat_div.sv
hw/rtl/sat_back.sv
hw/rtl/segment_address_translator.sv
sim/tb.sv
